// ----- src/box_average_ascii_downscale_macros.svh -----
// Assertion macros shared by the checker of the ASCII downscaler.
`ifndef BOX_AVERAGE_ASCII_DOWNSCALE_MACROS_SVH
`define BOX_AVERAGE_ASCII_DOWNSCALE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define BADA_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bada check failed");

// Next-cycle implication, quiet while reset is asserted.
`define BADA_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bada check failed");

`endif

// ----- src/bada_pkg.sv -----
// Shared types, constants and the palette of the ASCII downscaler.
`timescale 1ns / 1ps
package bada_pkg;

  localparam int DIM_W              = 13;
  localparam int OW_REG_W           = 9;
  localparam int GRAY_W             = 8;
  localparam int HSUM_W             = 21;
  localparam int SUM_W              = 34;
  localparam int CFG_IDX_W          = 8;
  localparam int DIM_LIMIT          = 8191;
  localparam int DEF_MAX_OUT_WIDTH  = 256;
  localparam int DEF_MAX_IN_DIM     = 4096;
  localparam int QUEUE_DEPTH        = 8;

  localparam logic [DIM_W-1:0]    RST_IN_WIDTH   = 13'd640;
  localparam logic [DIM_W-1:0]    RST_IN_HEIGHT  = 13'd480;
  localparam logic [OW_REG_W-1:0] RST_OUT_WIDTH  = 9'd80;
  localparam logic [DIM_W-1:0]    RST_OUT_HEIGHT = 13'd40;

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 8'd4;

  localparam logic [3:0] PAL_LAST = 4'd9;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
  } in_item_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  // One finished cell handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DIM_W-1:0] box_w;
    logic [DIM_W-1:0] box_h;
    logic             row_end;
    logic             frame_end;
  } cell_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  function automatic logic [7:0] glyph_of(input logic [3:0] idx);
    logic [7:0] g;
    case (idx)
      4'd0:    g = 8'h40;
      4'd1:    g = 8'h25;
      4'd2:    g = 8'h23;
      4'd3:    g = 8'h2A;
      4'd4:    g = 8'h2B;
      4'd5:    g = 8'h3D;
      4'd6:    g = 8'h2D;
      4'd7:    g = 8'h3A;
      4'd8:    g = 8'h2E;
      default: g = 8'h20;
    endcase
    return g;
  endfunction

endpackage

// ----- src/bada_in_if.sv -----
// Pixel stream interface.
`timescale 1ns / 1ps
interface bada_in_if;
  logic               valid;
  logic               ready;
  bada_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bada_out_if.sv -----
// Glyph stream interface.
`timescale 1ns / 1ps
interface bada_out_if;
  logic                valid;
  logic                ready;
  bada_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/bada_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bada_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- src/bada_div.sv -----
// Restoring divider, one quotient bit per cycle, for the box boundary steps.
`timescale 1ns / 1ps
module bada_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bada_pkg::DIM_W-1:0] num,
  input  logic [bada_pkg::DIM_W-1:0] den,
  output logic [bada_pkg::DIM_W-1:0] quo,
  output logic [bada_pkg::DIM_W-1:0] rem,
  output bada_pkg::div_stat_t        stat
);
  localparam int W = bada_pkg::DIM_W;

  logic         busy_r;
  logic [3:0]   cnt_r;
  logic [W-1:0] num_r;
  logic [W-1:0] den_r;
  logic [W-1:0] rem_r;
  logic [W:0]   trial;
  logic         ge;

  assign trial = {rem_r, num_r[W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 4'(W - 1);
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? W'(trial - {1'b0, den_r}) : W'(trial);
      num_r <= {num_r[W-2:0], ge};
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  assign quo       = num_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
endmodule

// ----- src/bada_fifo.sv -----
// Short cell queue between the front and the back.
`timescale 1ns / 1ps
module bada_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bada_pkg::cell_t push_data,
  input  logic            pop,
  output bada_pkg::cell_t head,
  output logic            empty,
  output logic            room
);
  localparam int D  = bada_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  bada_pkg::cell_t ent_r [D];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   rp_r;
  logic [PW:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  assign head  = ent_r[rp_r];
  assign empty = (cnt_r == '0);
  // Leave space for the two cells that may already be in the front pipeline.
  assign room  = cnt_r <= (PW+1)'(D - 3);
endmodule

// ----- src/bada_front.sv -----
// Front: config, box tracking and per-column sums; emits finished cells.
`timescale 1ns / 1ps
module bada_front #(
  parameter int MAX_OUT_WIDTH = bada_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_IN_DIM    = bada_pkg::DEF_MAX_IN_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bada_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bada_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           pix_valid,
  output logic                           pix_ready,
  input  logic [bada_pkg::GRAY_W-1:0]    pix_gray,
  input  logic                           room,
  output logic                           push,
  output bada_pkg::cell_t                push_data
);
  localparam int DW    = bada_pkg::DIM_W;
  localparam int SW    = bada_pkg::SUM_W;
  localparam int HW    = bada_pkg::HSUM_W;
  localparam int CW    = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int MAXD_I = (MAX_IN_DIM > bada_pkg::DIM_LIMIT) ? bada_pkg::DIM_LIMIT : MAX_IN_DIM;
  localparam int MOW_I  = (MAX_OUT_WIDTH > bada_pkg::DIM_LIMIT) ?
                          bada_pkg::DIM_LIMIT : MAX_OUT_WIDTH;
  localparam logic [DW-1:0] MAXD = DW'(MAXD_I);
  localparam logic [DW-1:0] MOW  = DW'(MOW_I);
  localparam logic [DW-1:0] ONE  = DW'(1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state_r;

  logic [DW-1:0]                 in_width_r, in_height_r, out_height_r;
  logic [bada_pkg::OW_REG_W-1:0] out_width_r;

  logic [DW-1:0] iw_c, ih_c, ow_cap, ow_c, oh_c, ow_ext;
  logic [DW-1:0] eff_iw_r, eff_ih_r, eff_ow_r, eff_oh_r;

  logic [DW-1:0] qx, rx, qy, ry;
  bada_pkg::div_stat_t xstat, ystat;
  logic div_start;

  logic [DW-1:0] px_r, py_r;
  logic [CW-1:0] cell_col_r;
  logic [DW-1:0] col_start_r, col_end_r, col_rem_r;
  logic [DW-1:0] row_start_r, row_end_r, row_rem_r;
  logic [HW-1:0] hsum_r;
  logic [MAX_OUT_WIDTH-1:0] vld_r;

  logic          s1_v_r, s1_emit_r, s1_re_r, s1_fe_r, s1_hit_r, s1_vld_r;
  logic [CW-1:0] s1_col_r;
  logic [HW-1:0] s1_part_r;
  logic [DW-1:0] s1_bw_r, s1_bh_r;
  logic [SW-1:0] s1_hitd_r;

  logic          acc, col_last, row_last, line_end, frame_last;
  logic [HW-1:0] hsum_in;
  logic [DW:0]   csum, rsum;
  logic          cwrap, rwrap;
  logic [DW-1:0] col_end_nx, col_rem_nx, row_end_nx, row_rem_nx;
  logic [SW-1:0] ram_rd, base, total, wdata;

  // Saturate the size registers.
  always_comb begin
    iw_c   = (in_width_r == '0) ? ONE : ((in_width_r > MAXD) ? MAXD : in_width_r);
    ih_c   = (in_height_r == '0) ? ONE : ((in_height_r > MAXD) ? MAXD : in_height_r);
    ow_cap = (iw_c < MOW) ? iw_c : MOW;
    ow_ext = DW'(out_width_r);
    ow_c   = (ow_ext == '0) ? ONE : ((ow_ext > ow_cap) ? ow_cap : ow_ext);
    oh_c   = (out_height_r == '0) ? ONE : ((out_height_r > ih_c) ? ih_c : out_height_r);
  end

  assign div_start = (state_r == ST_LOAD);

  bada_div u_xdiv (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(iw_c), .den(ow_c),
    .quo(qx), .rem(rx), .stat(xstat)
  );

  bada_div u_ydiv (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(ih_c), .den(oh_c),
    .quo(qy), .rem(ry), .stat(ystat)
  );

  assign pix_ready  = (state_r == ST_RUN) && room;
  assign acc        = pix_valid && pix_ready;
  assign col_last   = ({1'b0, px_r} + 1'b1) >= {1'b0, col_end_r};
  assign row_last   = ({1'b0, py_r} + 1'b1) >= {1'b0, row_end_r};
  assign line_end   = col_end_r >= eff_iw_r;
  assign frame_last = row_end_r >= eff_ih_r;
  assign hsum_in    = hsum_r + HW'(pix_gray);

  // Step the boundaries by quotient plus carry of the remainder.
  always_comb begin
    csum       = {1'b0, col_rem_r} + {1'b0, rx};
    cwrap      = csum >= {1'b0, eff_ow_r};
    col_rem_nx = cwrap ? DW'(csum - {1'b0, eff_ow_r}) : DW'(csum);
    col_end_nx = col_end_r + qx + DW'(cwrap);
    rsum       = {1'b0, row_rem_r} + {1'b0, ry};
    rwrap      = rsum >= {1'b0, eff_oh_r};
    row_rem_nx = rwrap ? DW'(rsum - {1'b0, eff_oh_r}) : DW'(rsum);
    row_end_nx = row_end_r + qy + DW'(rwrap);
  end

  bada_ram #(.WIDTH(SW), .DEPTH(MAX_OUT_WIDTH), .AW(CW)) u_sums (
    .clk(clk), .we(s1_v_r), .waddr(s1_col_r), .wdata(wdata),
    .raddr(cell_col_r), .rdata(ram_rd)
  );

  // Second stage: merge the row fragment into the column sum.
  always_comb begin
    base  = s1_hit_r ? s1_hitd_r : (s1_vld_r ? ram_rd : '0);
    total = base + SW'(s1_part_r);
    wdata = s1_emit_r ? '0 : total;
  end

  assign push                = s1_v_r && s1_emit_r;
  assign push_data.sum       = total;
  assign push_data.box_w     = s1_bw_r;
  assign push_data.box_h     = s1_bh_r;
  assign push_data.row_end   = s1_re_r;
  assign push_data.frame_end = s1_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      in_width_r   <= bada_pkg::RST_IN_WIDTH;
      in_height_r  <= bada_pkg::RST_IN_HEIGHT;
      out_width_r  <= bada_pkg::RST_OUT_WIDTH;
      out_height_r <= bada_pkg::RST_OUT_HEIGHT;
      vld_r        <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      s1_v_r <= 1'b0;
      if (s1_v_r) begin
        vld_r[s1_col_r] <= 1'b1;
      end
      case (state_r)
        ST_LOAD: begin
          eff_iw_r    <= iw_c;
          eff_ih_r    <= ih_c;
          eff_ow_r    <= ow_c;
          eff_oh_r    <= oh_c;
          vld_r       <= '0;
          px_r        <= '0;
          py_r        <= '0;
          cell_col_r  <= '0;
          col_start_r <= '0;
          row_start_r <= '0;
          hsum_r      <= '0;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (!xstat.busy && !ystat.busy) begin
            col_end_r <= qx;
            col_rem_r <= rx;
            row_end_r <= qy;
            row_rem_r <= ry;
            state_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (acc) begin
            if (col_last) begin
              s1_v_r    <= 1'b1;
              s1_col_r  <= cell_col_r;
              s1_part_r <= hsum_in;
              s1_emit_r <= row_last;
              s1_bw_r   <= col_end_r - col_start_r;
              s1_bh_r   <= row_end_r - row_start_r;
              s1_re_r   <= line_end;
              s1_fe_r   <= line_end && frame_last;
              s1_vld_r  <= vld_r[cell_col_r];
              // Catch the write that lands in the same cycle as this read.
              s1_hit_r  <= s1_v_r && (s1_col_r == cell_col_r);
              s1_hitd_r <= wdata;
              hsum_r    <= '0;
            end else begin
              hsum_r <= hsum_in;
            end
            if (!col_last) begin
              px_r <= px_r + 1'b1;
            end else if (!line_end) begin
              px_r        <= px_r + 1'b1;
              cell_col_r  <= cell_col_r + 1'b1;
              col_start_r <= col_end_r;
              col_end_r   <= col_end_nx;
              col_rem_r   <= col_rem_nx;
            end else begin
              px_r        <= '0;
              cell_col_r  <= '0;
              col_start_r <= '0;
              col_end_r   <= qx;
              col_rem_r   <= rx;
              if (row_last && frame_last) begin
                py_r        <= '0;
                row_start_r <= '0;
                row_end_r   <= qy;
                row_rem_r   <= ry;
              end else begin
                py_r <= py_r + 1'b1;
                if (row_last) begin
                  row_start_r <= row_end_r;
                  row_end_r   <= row_end_nx;
                  row_rem_r   <= row_rem_nx;
                end
              end
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
      if (cfg_wr_en && (cfg_index < bada_pkg::REG_COUNT)) begin
        state_r <= ST_LOAD;
        case (cfg_index)
          bada_pkg::REG_IN_WIDTH:   in_width_r   <= cfg_data;
          bada_pkg::REG_IN_HEIGHT:  in_height_r  <= cfg_data;
          bada_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_data[bada_pkg::OW_REG_W-1:0];
          bada_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- src/bada_back.sv -----
// Back: turns a cell sum into its palette glyph and holds it for the sink.
`timescale 1ns / 1ps
module bada_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  bada_pkg::cell_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bada_pkg::out_item_t out_data
);
  localparam int SW = bada_pkg::SUM_W;
  localparam int NW = SW + 4;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_SCL  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]          st_r;
  bada_pkg::cell_t     cell_r;
  logic [NW-1:0]       n_r, acc_r;
  logic [SW-1:0]       d_r;
  logic [3:0]          idx_r;
  bada_pkg::out_item_t out_r;
  logic [NW:0]         trial;

  assign pop   = (st_r == B_IDLE) && !empty;
  assign trial = {1'b0, acc_r} + (NW+1)'(d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (!empty) begin
            cell_r <= head;
            st_r   <= B_MUL;
          end
        end
        B_MUL: begin
          n_r  <= (NW'(cell_r.sum) << 3) + NW'(cell_r.sum);
          d_r  <= SW'(cell_r.box_w) * SW'(cell_r.box_h);
          st_r <= B_SCL;
        end
        B_SCL: begin
          d_r   <= (d_r << 8) - d_r;
          acc_r <= '0;
          idx_r <= '0;
          st_r  <= B_DIV;
        end
        B_DIV: begin
          // Advance while one more multiple of 255*count fits under 9*sum.
          if ((idx_r != bada_pkg::PAL_LAST) && (trial <= {1'b0, n_r})) begin
            acc_r <= NW'(trial);
            idx_r <= idx_r + 4'd1;
          end else begin
            out_r.glyph     <= bada_pkg::glyph_of(idx_r);
            out_r.row_end   <= cell_r.row_end;
            out_r.frame_end <= cell_r.frame_end;
            st_r            <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ready) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = (st_r == B_OUT);
  assign out_data  = out_r;
endmodule

// ----- src/box_average_ascii_downscale.sv -----
// Pixels are accepted one per cycle while the 8-entry cell queue has space.
// A glyph follows the pixel that closes its cell through the queue and the glyph unit,
// which multiplies, scales, steps through the palette (up to nine steps) and holds it.
// Reset and every write to one of the four size registers start a setup (13-step
// boundary divider) with in_ch.ready low; sums and positions restart there.
`timescale 1ns / 1ps
module box_average_ascii_downscale #(
  parameter int MAX_OUT_WIDTH = bada_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_IN_DIM    = bada_pkg::DEF_MAX_IN_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bada_in_if.sink                        in_ch,
  bada_out_if.source                     out_ch,
  input  logic                           cfg_wr_en,
  input  logic [bada_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bada_pkg::DIM_W-1:0]     cfg_data
);
  logic            push, pop, empty, room;
  bada_pkg::cell_t push_data, head;

  bada_front #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_IN_DIM(MAX_IN_DIM)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix_valid(in_ch.valid), .pix_ready(in_ch.ready), .pix_gray(in_ch.data.gray),
    .room(room), .push(push), .push_data(push_data)
  );

  bada_fifo u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
    .pop(pop), .head(head), .empty(empty), .room(room)
  );

  bada_back u_back (
    .clk(clk), .rst_n(rst_n), .empty(empty), .head(head), .pop(pop),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

// ----- src/bada_checker.sv -----
// Port-level checks for the ASCII downscaler, bound to its top level.
`timescale 1ns / 1ps
`include "box_average_ascii_downscale_macros.svh"
module bada_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [7:0]                     out_glyph,
  input logic                           out_row_end,
  input logic                           out_frame_end,
  input logic                           cfg_wr_en,
  input logic [bada_pkg::CFG_IDX_W-1:0] cfg_index
);
  logic pal_ok;

  assign pal_ok = (out_glyph == 8'h40) || (out_glyph == 8'h25) || (out_glyph == 8'h23) ||
                  (out_glyph == 8'h2A) || (out_glyph == 8'h2B) || (out_glyph == 8'h3D) ||
                  (out_glyph == 8'h2D) || (out_glyph == 8'h3A) || (out_glyph == 8'h2E) ||
                  (out_glyph == 8'h20);

  `BADA_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_glyph))
  `BADA_IMPLIES(a_palette, out_valid, pal_ok)
  `BADA_IMPLIES(a_frame_row, out_valid && out_frame_end, out_row_end)
  `BADA_NEXT(a_cfg_stall, cfg_wr_en && (cfg_index < bada_pkg::REG_COUNT), !in_ready)
endmodule

bind box_average_ascii_downscale bada_checker u_bada_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_glyph(out_ch.data.glyph), .out_row_end(out_ch.data.row_end),
  .out_frame_end(out_ch.data.frame_end),
  .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index)
);

// ----- verif/box_average_ascii_downscale_tb.sv -----
// Testbench of the ASCII box-average downscaler: directed and random frames checked by a scoreboard.
`timescale 1ns / 1ps
module box_average_ascii_downscale_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;

  // Running model of the downscaler and the queue of glyphs it still owes.
  class glyph_scoreboard;
    int unsigned reg_iw = 640, reg_ih = 480, reg_ow = 80, reg_oh = 40;
    longint unsigned col_sum [256];
    int unsigned px, py, ccol, crow, cbs, cbe, rbs, rbe;
    int unsigned ew, eh, eow, eoh;
    bada_pkg::out_item_t owed_q[$];
    int errors;
    int matched;
    string palette = "@%#*+=-:. ";

    function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int unsigned bound(int unsigned k, int unsigned n_in, int unsigned n_out);
      longint unsigned p;
      p = longint'(k) * longint'(n_in);
      return int'(p / n_out);
    endfunction

    function void restart();
      ew = clampu(reg_iw, 1, bada_pkg::DEF_MAX_IN_DIM);
      eh = clampu(reg_ih, 1, bada_pkg::DEF_MAX_IN_DIM);
      eow = clampu(reg_ow, 1, (ew < bada_pkg::DEF_MAX_OUT_WIDTH) ?
                   ew : bada_pkg::DEF_MAX_OUT_WIDTH);
      eoh = clampu(reg_oh, 1, eh);
      foreach (col_sum[i]) col_sum[i] = 0;
      px = 0; py = 0; ccol = 0; crow = 0; cbs = 0; rbs = 0;
      cbe = bound(1, ew, eow);
      rbe = bound(1, eh, eoh);
    endfunction

    function void set_reg(logic [bada_pkg::CFG_IDX_W-1:0] idx,
                          logic [bada_pkg::DIM_W-1:0] v);
      case (idx)
        bada_pkg::REG_IN_WIDTH:   reg_iw = v;
        bada_pkg::REG_IN_HEIGHT:  reg_ih = v;
        bada_pkg::REG_OUT_WIDTH:  reg_ow = v[bada_pkg::OW_REG_W-1:0];
        bada_pkg::REG_OUT_HEIGHT: reg_oh = v;
        default:                  return;
      endcase
      restart();
    endfunction

    // Note one accepted pixel; queue the glyph if it closes a cell.
    function void take_pixel(logic [7:0] g);
      int unsigned c;
      bit col_last, row_last, line_end;
      longint unsigned cnt, idx;
      bada_pkg::out_item_t e;
      c = (ccol < 256) ? ccol : 255;
      col_last = (px + 1 >= cbe);
      row_last = (py + 1 >= rbe);
      line_end = (cbe >= ew);
      col_sum[c] += g;
      if (col_last && row_last) begin
        cnt = longint'(cbe - cbs) * longint'(rbe - rbs);
        idx = (9 * col_sum[c]) / (255 * cnt);
        if (idx > 9) idx = 9;
        e.glyph = palette[idx];
        e.row_end = line_end;
        e.frame_end = line_end && (rbe >= eh);
        owed_q.push_back(e);
        col_sum[c] = 0;
      end
      if (!col_last) begin
        px++;
      end else if (!line_end) begin
        px++;
        ccol++;
        cbs = cbe;
        cbe = bound(ccol + 1, ew, eow);
      end else if (row_last && rbe >= eh) begin
        restart();
      end else begin
        px = 0; ccol = 0; cbs = 0;
        cbe = bound(1, ew, eow);
        py++;
        if (row_last) begin
          crow++;
          rbs = rbe;
          rbe = bound(crow + 1, eh, eoh);
        end
      end
    endfunction

    function void check(bada_pkg::out_item_t got);
      bada_pkg::out_item_t e;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected glyph %h row_end %b frame_end %b", $time,
                 got.glyph, got.row_end, got.frame_end);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      matched++;
      if (got.glyph !== e.glyph) begin
        $display("%0t: glyph expected %h actual %h", $time, e.glyph, got.glyph);
        errors++;
      end
      if (got.row_end !== e.row_end) begin
        $display("%0t: row_end expected %b actual %b", $time, e.row_end, got.row_end);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, e.frame_end,
                 got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [bada_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bada_pkg::DIM_W-1:0] cfg_data = '0;

  bada_in_if in_ch ();
  bada_out_if out_ch ();

  box_average_ascii_downscale u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_scoreboard sb;
  int cycle;
  int pixels_sent;
  int phases;
  int burst_left;
  int hold_req;
  int hold_seen;
  int hold_left;
  int stall_mode;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: check each word, then pick next ready from the stall pattern or a long hold.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
    if (cycle % 256 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= (cycle % 5) > 1;
      endcase
    end
  end

  task automatic send_pixel(input logic [7:0] g);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data.gray <= g;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_pixel(g);
    pixels_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bada_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[bada_pkg::DIM_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, v[bada_pkg::DIM_W-1:0]);
  endtask

  task automatic set_sizes(input int unsigned iw, input int unsigned ih,
                           input int unsigned ow, input int unsigned oh);
    go_idle();
    write_reg(bada_pkg::REG_IN_WIDTH, iw);
    write_reg(bada_pkg::REG_IN_HEIGHT, ih);
    write_reg(bada_pkg::REG_OUT_WIDTH, ow);
    write_reg(bada_pkg::REG_OUT_HEIGHT, oh);
    phases++;
  endtask

  function automatic logic [7:0] pick_gray();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int unsigned n, frame;
    sb = new();
    sb.restart();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sizes of zero saturate to one: every pixel is its own cell.
    set_sizes(0, 0, 5, 9);
    send_pixel(8'd0); send_pixel(8'd255); send_pixel(8'd1);
    send_pixel(8'd254); send_pixel(8'd28); send_pixel(8'd29);
    // Output sizes above the input sizes clamp down.
    set_sizes(4, 3, 511, 0);
    for (int i = 0; i < 12; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
    // Unknown register index leaves the frame position alone.
    set_sizes(3, 2, 3, 2);
    for (int i = 0; i < 3; i++) send_pixel(8'd200);
    go_idle();
    write_reg(bada_pkg::REG_COUNT, 13'h1FFF);
    for (int i = 0; i < 3; i++) send_pixel(8'd100);

    // Widest input clamps to the limit; start of its line.
    set_sizes(13'h1FFF, 1, 256, 1);
    for (int i = 0; i < 64; i++) send_pixel(pick_gray());
    // Widest output row, one pixel per cell, one line frame.
    set_sizes(256, 1, 300, 1);
    for (int i = 0; i < 256; i++) send_pixel(pick_gray());
    // One column, tall output clamped to the input height.
    set_sizes(120, 2, 1, 4096);
    for (int i = 0; i < 240; i++) send_pixel(pick_gray());

    // Keep pushing while the receiver is held off so the queue backs up.
    set_sizes(8, 4, 8, 4);
    hold_req++;
    for (int i = 0; i < 100; i++) send_pixel(pick_gray());

    while (pixels_sent < 1250) begin
      set_sizes($urandom_range(0, 16), $urandom_range(0, 8),
                $urandom_range(0, 20), $urandom_range(0, 10));
      n = sb.ew * sb.eh;
      frame = $urandom_range(1, 2) * n;
      if ($urandom_range(0, 4) == 0) frame = frame + $urandom_range(0, n);
      for (int i = 0; i < frame; i++) send_pixel(pick_gray());
    end

    go_idle();
    $display("Ran %0d pixels over %0d size settings, %0d glyphs matched.",
             pixels_sent, phases, sb.matched);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- box_average_ascii_downscale.f -----
+incdir+src
src/bada_pkg.sv
src/bada_in_if.sv
src/bada_out_if.sv
src/bada_ram.sv
src/bada_div.sv
src/bada_fifo.sv
src/bada_front.sv
src/bada_back.sv
src/box_average_ascii_downscale.sv
src/bada_checker.sv
verif/box_average_ascii_downscale_tb.sv
